// ===== hdl/mcng_pkg.sv =====
// Shared types and constants for the multichannel noise gate.
`timescale 1ns / 1ps
`default_nettype none
package mcng_pkg;

  localparam int CHANNELS  = 2;
  localparam int SAMPLE_W  = 16;
  localparam int MAG_W     = SAMPLE_W + 1;
  localparam int ENV_W     = 17;
  localparam int THRESH_W  = 16;
  localparam int COEFF_W   = 17;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_W    = 16;

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

  localparam logic [THRESH_W-1:0] THRESH_RESET  = THRESH_W'(328);
  localparam logic [COEFF_W-1:0]  ATTACK_RESET  = COEFF_W'(65536);
  localparam logic [COEFF_W-1:0]  RELEASE_RESET = COEFF_W'(65);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ATTACK    = 2'd1,
    REG_RELEASE   = 2'd2
  } cfg_reg_t;

  // Per-phase strobes that walk one word through the datapath.
  typedef struct packed {
    logic load;      // capture samples and magnitudes
    logic step;      // peak, target and envelope step product
    logic update;    // apply the step to the envelope
    logic mul;       // sample times new envelope
    logic out_load;  // round products into the output register
  } ctl_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [MAG_W-1:0]           mag_t;

endpackage
`default_nettype wire

// ===== hdl/mcng_lane.sv =====
// One channel lane: magnitude of the sample and the gated, rounded product.
`timescale 1ns / 1ps
`default_nettype none
module mcng_lane import mcng_pkg::*; (
  input  wire logic             clk,
  input  wire ctl_t             ctl,
  input  wire sample_t          sample,
  input  wire logic [ENV_W-1:0] envelope,
  output mag_t                  mag,
  output sample_t               gated
);

  logic signed [MAG_W-1:0]            sample_ext;
  sample_t                            sample_q;
  logic signed [SAMPLE_W+ENV_W:0]     prod;
  logic signed [SAMPLE_W+ENV_W:0]     prod_rnd;

  assign sample_ext = {sample[SAMPLE_W-1], sample};

  // Capture the sample and its magnitude; the most negative code gives 32768
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sample_q <= sample;
      mag      <= sample[SAMPLE_W-1] ? mag_t'(MAG_W'(0) - sample_ext) : mag_t'(sample_ext);
    end
  end

  // Multiply by the updated envelope
  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= sample_q * $signed({1'b0, envelope});
    end
  end

  // Round half up and drop the fraction
  assign prod_rnd = (prod + (SAMPLE_W+ENV_W+1)'(32768)) >>> FRAC_W;

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      gated <= prod_rnd[SAMPLE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mcng_env.sv =====
// Merge stage: peak over the lanes, gate decision and envelope update.
`timescale 1ns / 1ps
`default_nettype none
module mcng_env import mcng_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ctl_t                ctl,
  input  wire mag_t                mags [CHANNELS],
  input  wire logic [THRESH_W-1:0] threshold,
  input  wire logic [COEFF_W-1:0]  attack_coeff,
  input  wire logic [COEFF_W-1:0]  release_coeff,
  output logic [ENV_W-1:0]         envelope
);

  localparam int DELTA_W = ENV_W + 1;
  localparam int PROD_W  = DELTA_W + COEFF_W + 1;
  localparam int SUM_W   = ENV_W + 3;

  mag_t                      peak;
  logic [ENV_W-1:0]          target;
  logic [COEFF_W-1:0]        coeff;
  logic signed [DELTA_W-1:0] delta;
  logic signed [PROD_W-1:0]  prod;
  logic signed [PROD_W-1:0]  prod_rnd;
  logic signed [SUM_W-1:0]   sum;
  logic [ENV_W-1:0]          envelope_next;

  // Peak magnitude over the lanes
  always_comb begin
    peak = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (mags[i] > peak) begin
        peak = mags[i];
      end
    end
  end

  // Open fully when the peak is strictly above threshold
  assign target = (peak > mag_t'(threshold)) ? ENV_ONE : '0;
  assign coeff  = (target > envelope) ? attack_coeff : release_coeff;
  assign delta  = $signed({1'b0, target}) - $signed({1'b0, envelope});

  // Register the step product before it reaches the envelope
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      prod <= delta * $signed({1'b0, coeff});
    end
  end

  // Round half up, add, and clamp to the closed..open range
  assign prod_rnd = (prod + PROD_W'(32768)) >>> FRAC_W;
  assign sum      = $signed({3'b000, envelope}) + prod_rnd[SUM_W-1:0];

  always_comb begin
    priority if (sum < 0) begin
      envelope_next = '0;
    end else if (sum > $signed({3'b000, ENV_ONE})) begin
      envelope_next = ENV_ONE;
    end else begin
      envelope_next = sum[ENV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      envelope <= '0;
    end else if (ctl.update) begin
      envelope <= envelope_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/multichannel_noise_gate_core.sv =====
// Noise gate with attack/release envelope over a multichannel frame.
// Phases: load, step, update, multiply, then round into the output register;
// the envelope feedback (step multiply, update, gain multiply) holds one
// frame in flight at a time; the next is taken when that one is output.
// Reset: envelope closed (0), threshold 328, attack 65536, release 65.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_noise_gate_core import mcng_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data,
  input  wire logic                   sample_valid,
  output logic                        sample_stall,
  input  wire logic signed [15:0]     sample_ch0,
  input  wire logic signed [15:0]     sample_ch1,
  output logic                        gated_valid,
  input  wire logic                   gated_stall,
  output logic signed [15:0]          gated_ch0,
  output logic signed [15:0]          gated_ch1,
  output logic [ENV_W-1:0]            envelope_level
);

  logic [THRESH_W-1:0] threshold;
  logic [COEFF_W-1:0]  attack_coeff;
  logic [COEFF_W-1:0]  release_coeff;

  logic    busy;
  logic    ph_step;
  logic    ph_update;
  logic    ph_mul;
  logic    ph_done;
  logic    accept;
  ctl_t    ctl;
  sample_t samples [CHANNELS];
  mag_t    mags    [CHANNELS];
  sample_t gated   [CHANNELS];
  logic [ENV_W-1:0] envelope;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESH_RESET;
      attack_coeff  <= ATTACK_RESET;
      release_coeff <= RELEASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold     <= cfg_data[THRESH_W-1:0];
        REG_ATTACK:    attack_coeff  <= cfg_data[COEFF_W-1:0];
        REG_RELEASE:   release_coeff <= cfg_data[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Phase control: one word at a time, output register parts the sides
  assign ctl.out_load = ph_done && (!gated_valid || !gated_stall);
  assign sample_stall = busy && !ctl.out_load;
  assign accept       = sample_valid && !sample_stall;
  assign ctl.load     = accept;
  assign ctl.step     = ph_step;
  assign ctl.update   = ph_update;
  assign ctl.mul      = ph_mul;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      ph_step     <= 1'b0;
      ph_update   <= 1'b0;
      ph_mul      <= 1'b0;
      ph_done     <= 1'b0;
      gated_valid <= 1'b0;
    end else begin
      ph_step   <= accept;
      ph_update <= ph_step;
      ph_mul    <= ph_update;
      if (ph_mul) begin
        ph_done <= 1'b1;
      end else if (ctl.out_load) begin
        ph_done <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (ctl.out_load) begin
        busy <= 1'b0;
      end
      if (ctl.out_load) begin
        gated_valid <= 1'b1;
      end else if (!gated_stall) begin
        gated_valid <= 1'b0;
      end
    end
  end

  // Hold the envelope with the output word
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      envelope_level <= envelope;
    end
  end

  assign samples[0] = sample_ch0;
  assign samples[1] = sample_ch1;

  for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
    mcng_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .sample   (samples[i]),
      .envelope (envelope),
      .mag      (mags[i]),
      .gated    (gated[i])
    );
  end

  mcng_env u_env (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .mags          (mags),
    .threshold     (threshold),
    .attack_coeff  (attack_coeff),
    .release_coeff (release_coeff),
    .envelope      (envelope)
  );

  assign gated_ch0 = gated[0];
  assign gated_ch1 = gated[1];

endmodule
`default_nettype wire

// ===== test/mcng_gate_checker.sv =====
// Checker for the noise gate: predicts every gated word from the accepted frames and compares.
`timescale 1ns / 1ps
module mcng_gate_checker import mcng_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 sample_valid,
  input  logic                 sample_stall,
  input  sample_t              sample_ch0,
  input  sample_t              sample_ch1,
  input  logic                 gated_valid,
  input  logic                 gated_stall,
  input  sample_t              gated_ch0,
  input  sample_t              gated_ch1,
  input  logic [ENV_W-1:0]     envelope_level,
  output int                   mismatches,
  output int                   pending
);

  typedef struct packed {
    sample_t          g0;
    sample_t          g1;
    logic [ENV_W-1:0] env;
  } gated_word_t;

  // Shadow copy of the gate settings and the envelope
  logic [THRESH_W-1:0] thr_r;
  logic [COEFF_W-1:0]  attack_r;
  logic [COEFF_W-1:0]  release_r;
  logic [ENV_W-1:0]    gate_env;
  gated_word_t         gated_q[$];
  int                  err_count = 0;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  // Divide by 65536 and round half up; arithmetic shift gives the floor
  function automatic longint rnd_q16(input longint p);
    return (p + 32768) >>> FRAC_W;
  endfunction

  // |-32768| counts as 32768
  function automatic longint magnitude(input sample_t s);
    return (s < 0) ? -longint'(s) : longint'(s);
  endfunction

  // Step the envelope for one frame and form the gated word
  function automatic gated_word_t gate_frame(input sample_t a, input sample_t b);
    longint      peak;
    longint      target;
    longint      coeff;
    longint      env;
    gated_word_t w;
    peak   = (magnitude(a) > magnitude(b)) ? magnitude(a) : magnitude(b);
    target = (peak > longint'(thr_r)) ? longint'(ENV_ONE) : 0;
    env    = longint'(gate_env);
    // equal envelope and target falls to release, with a zero step
    coeff  = (target > env) ? longint'(attack_r) : longint'(release_r);
    env    = env + rnd_q16(coeff * (target - env));
    // coefficients above 1.0 may overshoot: clamp to closed..open
    if (env < 0) env = 0;
    if (env > longint'(ENV_ONE)) env = longint'(ENV_ONE);
    gate_env = ENV_W'(env);
    w.g0  = SAMPLE_W'(rnd_q16(longint'(a) * env));
    w.g1  = SAMPLE_W'(rnd_q16(longint'(b) * env));
    w.env = ENV_W'(env);
    return w;
  endfunction

  always @(posedge clk) begin
    gated_word_t want;
    if (rst) begin
      thr_r     = THRESH_RESET;
      attack_r  = ATTACK_RESET;
      release_r = RELEASE_RESET;
      gate_env  = '0;
      gated_q.delete();
    end else begin
      // Track register writes; an unused index changes nothing
      if (cfg_we) begin
        case (cfg_index)
          REG_THRESHOLD: thr_r     = cfg_data[THRESH_W-1:0];
          REG_ATTACK:    attack_r  = cfg_data[COEFF_W-1:0];
          REG_RELEASE:   release_r = cfg_data[COEFF_W-1:0];
          default: ;
        endcase
      end
      // Compare the outgoing word against the oldest prediction
      if (gated_valid && !gated_stall) begin
        if (gated_q.size() == 0) begin
          $display("%0t gate check: word with no frame pending, ch0=%0d ch1=%0d env=%0d",
                   $time, gated_ch0, gated_ch1, envelope_level);
          err_count++;
        end else begin
          want = gated_q.pop_front();
          if (gated_ch0 !== want.g0) begin
            $display("%0t gate check: gated_ch0 expected %0d actual %0d",
                     $time, want.g0, gated_ch0);
            err_count++;
          end
          if (gated_ch1 !== want.g1) begin
            $display("%0t gate check: gated_ch1 expected %0d actual %0d",
                     $time, want.g1, gated_ch1);
            err_count++;
          end
          if (envelope_level !== want.env) begin
            $display("%0t gate check: envelope_level expected %0d actual %0d",
                     $time, want.env, envelope_level);
            err_count++;
          end
        end
      end
      // Predict the word for each accepted frame
      if (sample_valid && !sample_stall) gated_q.push_back(gate_frame(sample_ch0, sample_ch1));
    end
    mismatches <= err_count;
    pending    <= gated_q.size();
  end

endmodule

// ===== test/tb_multichannel_noise_gate_core.sv =====
// Testbench top for the noise gate core: clock, reset, frame and stall traffic, verdict.
`timescale 1ns / 1ps
module tb_multichannel_noise_gate_core;
  import mcng_pkg::*;

  localparam int GATE_LATENCY   = 6;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_FRAMES   = 230;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum {FRAME_QUIET, FRAME_LOUD, FRAME_NOISE} frame_kind_t;
  typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_RUNS} stall_kind_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  sample_t              sample_ch0   = '0;
  sample_t              sample_ch1   = '0;
  logic                 gated_valid;
  logic                 gated_stall  = 1'b0;
  sample_t              gated_ch0;
  sample_t              gated_ch1;
  logic [ENV_W-1:0]     envelope_level;
  int                   mismatches;
  int                   pending;

  int                   cur_thr = 328;
  int                   idle_cycles = 0;
  stall_kind_t          stall_kind = STALL_NONE;
  int                   stall_win = 0;
  int                   stall_run = 0;
  logic                 stall_hold = 1'b0;

  always #1 clk = ~clk;

  multichannel_noise_gate_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_ch0     (sample_ch0),
    .sample_ch1     (sample_ch1),
    .gated_valid    (gated_valid),
    .gated_stall    (gated_stall),
    .gated_ch0      (gated_ch0),
    .gated_ch1      (gated_ch1),
    .envelope_level (envelope_level)
  );

  mcng_gate_checker gate_chk (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .sample_ch0     (sample_ch0),
    .sample_ch1     (sample_ch1),
    .gated_valid    (gated_valid),
    .gated_stall    (gated_stall),
    .gated_ch0      (gated_ch0),
    .gated_ch1      (gated_ch1),
    .envelope_level (envelope_level),
    .mismatches     (mismatches),
    .pending        (pending)
  );

  // Receiver stall: a random pattern, changed when its window runs out
  always @(negedge clk) begin
    if (stall_win == 0) begin
      stall_kind = stall_kind_t'($urandom_range(3, 0));
      stall_win  = 64;
    end
    stall_win--;
    case (stall_kind)
      STALL_NONE:     gated_stall <= 1'b0;
      STALL_COIN:     gated_stall <= 1'($urandom_range(1, 0));
      STALL_PERIODIC: gated_stall <= (stall_win % 3 == 0);
      default: begin
        if (stall_run == 0) begin
          stall_hold = ~stall_hold;
          stall_run  = $urandom_range(12, 1);
        end
        stall_run--;
        gated_stall <= stall_hold;
      end
    endcase
  end

  // Watchdog: end the run after too long with no word moving
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (gated_valid && !gated_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one frame and hold it until accepted
  task automatic push_frame(input sample_t a, input sample_t b);
    @(negedge clk);
    sample_valid <= 1'b1;
    sample_ch0   <= a;
    sample_ch1   <= b;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // Drop valid for a number of cycles
  task automatic idle_gap(input int n);
    if (n > 0) begin
      @(negedge clk);
      sample_valid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Hold off until every predicted word is out, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (GATE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Reprogram the gate while idle; threshold writes carry a random spare top bit
  task automatic set_gate(input logic [THRESH_W-1:0] thr, input logic [COEFF_W-1:0] att,
                          input logic [COEFF_W-1:0] rel);
    settle();
    write_reg(REG_THRESHOLD, {1'($urandom_range(1, 0)), thr});
    write_reg(REG_ATTACK, att);
    write_reg(REG_RELEASE, rel);
    cur_thr = int'(thr);
  endtask

  function automatic sample_t signed_mag(input int mag);
    if (mag >= 32768) return sample_t'(-32768);
    return $urandom_range(1, 0) ? sample_t'(-mag) : sample_t'(mag);
  endfunction

  // Magnitude at or below the threshold, now and then exactly on it
  function automatic sample_t quiet_sample(input int thr);
    int m;
    m = (thr > 32768) ? 32768 : thr;
    return signed_mag(($urandom_range(7, 0) == 0) ? m : $urandom_range(m, 0));
  endfunction

  // Magnitude above the threshold, now and then just past it
  function automatic sample_t loud_sample(input int thr);
    if (thr >= 32768) return sample_t'($urandom);
    return signed_mag(($urandom_range(7, 0) == 0) ? thr + 1 : $urandom_range(32768, thr + 1));
  endfunction

  function automatic logic [THRESH_W-1:0] pick_thr();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return THRESH_W'(32768);
      2:       return '1;
      5:       return THRESH_W'($urandom_range(2000, 0));
      default: return THRESH_W'($urandom_range(32768, 0));
    endcase
  endfunction

  function automatic logic [COEFF_W-1:0] pick_coeff();
    case ($urandom_range(5, 0))
      0:       return '0;
      1:       return COEFF_W'(65536);
      2:       return '1;
      3:       return COEFF_W'($urandom_range(65536, 0));
      4:       return COEFF_W'($urandom_range(4096, 0));
      default: return COEFF_W'($urandom_range(131071, 0));
    endcase
  endfunction

  initial begin
    frame_kind_t kind;
    sample_t     a;
    sample_t     b;
    int          run;
    int          burst;
    bit          no_gaps;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: closed, threshold edge, full scale, release creep
    push_frame(0, 0);
    push_frame(328, -328);
    push_frame(329, 0);
    push_frame(32767, -32768);
    push_frame(-32768, 32767);
    push_frame(-1, 1);
    push_frame(0, 0);
    push_frame(100, -100);
    push_frame(0, -329);
    push_frame(1, 0);

    // Coefficients above 1.0: overshoot both ways, then envelope equal to target
    set_gate(0, '1, '1);
    push_frame(1, 0);
    push_frame(0, 0);
    push_frame(0, 0);
    push_frame(0, -1);

    // Threshold at full scale never opens; unused register index is ignored
    set_gate(THRESH_W'(32768), '0, '0);
    write_reg(REG_SPARE, '1);
    push_frame(-32768, -32768);
    push_frame(32767, 32767);
    push_frame(-32768, 0);

    set_gate('1, COEFF_W'(65536), COEFF_W'(32768));
    push_frame(-32768, 12345);
    set_gate(THRESH_W'(100), COEFF_W'(65536), COEFF_W'(32768));
    push_frame(0, 101);
    push_frame(0, 0);
    push_frame(0, 0);
    push_frame(-3, 5);

    // Random phases: runs of quiet and loud frames drive the envelope up and down
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_gate(pick_thr(), pick_coeff(), pick_coeff());
      if ($urandom_range(1, 0)) write_reg(REG_SPARE, CFG_W'($urandom));
      no_gaps = (phase % 4 == 3);
      burst   = $urandom_range(16, 1);
      run     = 0;
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        if (run == 0) begin
          case ($urandom_range(9, 0))
            0, 1, 2, 3: kind = FRAME_QUIET;
            4, 5, 6, 7: kind = FRAME_LOUD;
            default:    kind = FRAME_NOISE;
          endcase
          run = $urandom_range(40, 1);
        end
        run--;
        case (kind)
          FRAME_QUIET: begin
            a = quiet_sample(cur_thr);
            b = quiet_sample(cur_thr);
          end
          FRAME_LOUD: begin
            if ($urandom_range(1, 0)) begin
              a = loud_sample(cur_thr);
              b = $urandom_range(3, 0) ? quiet_sample(cur_thr) : loud_sample(cur_thr);
            end else begin
              a = quiet_sample(cur_thr);
              b = loud_sample(cur_thr);
            end
          end
          default: begin
            a = sample_t'($urandom);
            b = sample_t'($urandom);
          end
        endcase
        push_frame(a, b);
        burst--;
        if ($urandom_range(149, 0) == 0) begin
          settle();
        end else if (burst == 0) begin
          burst = $urandom_range(16, 1);
          if (!no_gaps) idle_gap($urandom_range(6, 0));
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
